[sv/lts_pkg.sv]
// Package for the lottery ticket scheduler: sizes, codes and sequencer states.
`default_nettype none
package lts_pkg;

    localparam int MAX_PROCS = 32;
    localparam int HEAD_SLOT = MAX_PROCS;
    localparam int TAIL_SLOT = MAX_PROCS + 1;
    localparam int LINK_W    = $clog2(MAX_PROCS + 2);
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int STEP_W    = $clog2(MAX_PROCS + 1);
    localparam int ID_W      = 5;
    localparam int TICK_W    = 16;
    localparam int TOTAL_W   = 21;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DRAW   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK         = 2'd0,
        STS_BAD_ID     = 2'd1,
        STS_DUP_ABSENT = 2'd2,
        STS_RANGE      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WALK_INS,
        ST_LINK_A,
        ST_LINK_B,
        ST_WALK_DRAW,
        ST_UNLINK,
        ST_FINISH
    } t_state;

endpackage
`default_nettype wire

[sv/lottery_ticket_scheduler_top.sv]
// Lottery ticket scheduler: ordered ready list, list walker and result register.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+------------------------------------------
//  in      | input     | i_valid / o_ready   | i_cmd, i_proc_id, i_tickets, i_random_value
//  out     | output    | o_valid / i_ready   | o_status, o_winner_id, o_ticket_total
//
// One word at a time. Insert runs START, the walk, LINK_A, LINK_B and FINISH; draw runs START,
// the walk, UNLINK and FINISH; a remove that unlinks runs START, UNLINK and FINISH, the rest
// START and FINISH. The walk checks one entry per cycle, tail included, set by the registered
// read of the link/ticket memories. Reset clears the flags, the head/tail links and the total.
// The next word is taken while a result waits in the output register; a stalled
// result holds the sequencer in its last state until the register frees.
`default_nettype none
module lottery_ticket_scheduler_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [1:0]                  i_cmd,
    input  wire logic [lts_pkg::ID_W-1:0]    i_proc_id,
    input  wire logic [lts_pkg::TICK_W-1:0]  i_tickets,
    input  wire logic [lts_pkg::TOTAL_W-1:0] i_random_value,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [1:0]                       o_status,
    output logic [lts_pkg::ID_W-1:0]         o_winner_id,
    output logic [lts_pkg::TOTAL_W-1:0]      o_ticket_total
);

    localparam int LW = lts_pkg::LINK_W;
    localparam int IW = lts_pkg::IDX_W;
    localparam int SW = lts_pkg::STEP_W;
    localparam int TW = lts_pkg::TICK_W;
    localparam int AW = lts_pkg::TOTAL_W;
    localparam int DW = lts_pkg::ID_W;
    localparam int NP = lts_pkg::MAX_PROCS;

    localparam logic [LW-1:0] HEAD = LW'(lts_pkg::HEAD_SLOT);
    localparam logic [LW-1:0] TAIL = LW'(lts_pkg::TAIL_SLOT);
    localparam logic [AW:0]   TOTAL_MAX = {1'b0, {AW{1'b1}}};

    // link and ticket memories for process slots; sentinel links live in registers
    logic [TW-1:0] r_tick_mem [NP];
    logic [LW-1:0] r_next_mem [NP];
    logic [LW-1:0] r_prev_mem [NP];
    logic [TW-1:0] r_tick_q;
    logic [LW-1:0] r_next_q;
    logic [LW-1:0] r_prev_q;

    lts_pkg::t_state  r_state, n_state;
    lts_pkg::t_cmd    r_cmd, n_cmd;
    lts_pkg::t_status r_status, n_status;
    logic [DW-1:0]    r_id, n_id;
    logic [TW-1:0]    r_key, n_key;
    logic [AW-1:0]    r_rnd, n_rnd;
    logic [LW-1:0]    r_cur, n_cur;
    logic [LW-1:0]    r_p, n_p;
    logic [SW-1:0]    r_steps, n_steps;
    logic [AW-1:0]    r_sum, n_sum;
    logic [DW-1:0]    r_winner, n_winner;
    logic [AW-1:0]    r_total, n_total;
    logic [NP-1:0]    r_queued, n_queued;
    logic [LW-1:0]    r_head_next, n_head_next;
    logic [LW-1:0]    r_tail_prev, n_tail_prev;
    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_o_status, n_o_status;
    logic [DW-1:0]    r_o_winner, n_o_winner;
    logic [AW-1:0]    r_o_total, n_o_total;

    logic [LW-1:0] rd_addr;
    logic          tk_we;
    logic          nx_we;
    logic [IW-1:0] nx_waddr;
    logic [LW-1:0] nx_wdata;
    logic          pv_we;
    logic [IW-1:0] pv_waddr;
    logic [LW-1:0] pv_wdata;

    logic          cur_is_proc;
    logic          id_bad;
    logic          ins_go_on;
    logic [AW:0]   ins_total;
    logic [AW-1:0] sum_add;
    logic [LW-1:0] id_link;

    assign id_link     = LW'(r_id);
    assign cur_is_proc = (r_cur < HEAD);
    assign id_bad      = (id_link >= HEAD);
    assign ins_total   = {1'b0, r_total} + (AW + 1)'(r_key);
    assign sum_add     = r_sum + AW'(r_tick_q);
    // keep walking past larger counts, and past equal counts of lower id
    assign ins_go_on   = cur_is_proc && (r_steps != SW'(NP)) &&
                         ((r_tick_q > r_key) || ((r_tick_q == r_key) && (r_cur < id_link)));

    always_ff @(posedge i_clk) begin
        if (tk_we) begin
            r_tick_mem[r_id[IW-1:0]] <= r_key;
        end
        if (nx_we) begin
            r_next_mem[nx_waddr] <= nx_wdata;
        end
        if (pv_we) begin
            r_prev_mem[pv_waddr] <= pv_wdata;
        end
        r_tick_q <= r_tick_mem[rd_addr[IW-1:0]];
        r_next_q <= r_next_mem[rd_addr[IW-1:0]];
        r_prev_q <= r_prev_mem[rd_addr[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lts_pkg::ST_IDLE;
            r_queued    <= '0;
            r_head_next <= TAIL;
            r_tail_prev <= HEAD;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_queued    <= n_queued;
            r_head_next <= n_head_next;
            r_tail_prev <= n_tail_prev;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_status   <= n_status;
        r_id       <= n_id;
        r_key      <= n_key;
        r_rnd      <= n_rnd;
        r_cur      <= n_cur;
        r_p        <= n_p;
        r_steps    <= n_steps;
        r_sum      <= n_sum;
        r_winner   <= n_winner;
        r_o_status <= n_o_status;
        r_o_winner <= n_o_winner;
        r_o_total  <= n_o_total;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_status    = r_status;
        n_id        = r_id;
        n_key       = r_key;
        n_rnd       = r_rnd;
        n_cur       = r_cur;
        n_p         = r_p;
        n_steps     = r_steps;
        n_sum       = r_sum;
        n_winner    = r_winner;
        n_total     = r_total;
        n_queued    = r_queued;
        n_head_next = r_head_next;
        n_tail_prev = r_tail_prev;
        n_out_valid = r_out_valid && !i_ready;
        n_o_status  = r_o_status;
        n_o_winner  = r_o_winner;
        n_o_total   = r_o_total;
        rd_addr     = r_cur;
        tk_we       = 1'b0;
        nx_we       = 1'b0;
        nx_waddr    = r_id[IW-1:0];
        nx_wdata    = r_cur;
        pv_we       = 1'b0;
        pv_waddr    = r_id[IW-1:0];
        pv_wdata    = r_p;
        o_ready     = 1'b0;

        case (r_state)
            lts_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_cmd   = lts_pkg::t_cmd'(i_cmd);
                    n_id    = i_proc_id;
                    n_key   = i_tickets;
                    n_rnd   = i_random_value;
                    n_state = lts_pkg::ST_START;
                end
            end
            lts_pkg::ST_START: begin
                n_status = lts_pkg::STS_OK;
                n_winner = '0;
                n_steps  = '0;
                n_sum    = '0;
                n_state  = lts_pkg::ST_FINISH;
                case (r_cmd)
                    lts_pkg::CMD_INSERT: begin
                        if (id_bad) begin
                            n_status = lts_pkg::STS_BAD_ID;
                        end else if (r_queued[r_id[IW-1:0]]) begin
                            n_status = lts_pkg::STS_DUP_ABSENT;
                        end else if (ins_total > TOTAL_MAX) begin
                            n_status = lts_pkg::STS_RANGE;
                        end else begin
                            n_cur   = r_head_next;
                            rd_addr = r_head_next;
                            n_state = lts_pkg::ST_WALK_INS;
                        end
                    end
                    lts_pkg::CMD_DRAW: begin
                        if (r_rnd >= r_total) begin
                            n_status = lts_pkg::STS_RANGE;
                        end else begin
                            n_cur   = r_head_next;
                            rd_addr = r_head_next;
                            n_state = lts_pkg::ST_WALK_DRAW;
                        end
                    end
                    lts_pkg::CMD_REMOVE: begin
                        if (id_bad) begin
                            n_status = lts_pkg::STS_BAD_ID;
                        end else if (!r_queued[r_id[IW-1:0]]) begin
                            n_status = lts_pkg::STS_DUP_ABSENT;
                        end else begin
                            n_cur   = id_link;
                            rd_addr = id_link;
                            n_state = lts_pkg::ST_UNLINK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            lts_pkg::ST_WALK_INS: begin
                if (ins_go_on) begin
                    n_cur   = r_next_q;
                    rd_addr = r_next_q;
                    n_steps = r_steps + SW'(1);
                end else begin
                    n_p     = cur_is_proc ? r_prev_q : r_tail_prev;
                    n_state = lts_pkg::ST_LINK_A;
                end
            end
            lts_pkg::ST_LINK_A: begin
                // own links and ticket count of the new entry, plus sentinel links
                tk_we    = 1'b1;
                nx_we    = 1'b1;
                nx_waddr = r_id[IW-1:0];
                nx_wdata = r_cur;
                pv_we    = 1'b1;
                pv_waddr = r_id[IW-1:0];
                pv_wdata = r_p;
                if (r_p == HEAD) begin
                    n_head_next = id_link;
                end
                if (r_cur == TAIL) begin
                    n_tail_prev = id_link;
                end
                n_state = lts_pkg::ST_LINK_B;
            end
            lts_pkg::ST_LINK_B: begin
                nx_we    = (r_p < HEAD);
                nx_waddr = r_p[IW-1:0];
                nx_wdata = id_link;
                pv_we    = cur_is_proc;
                pv_waddr = r_cur[IW-1:0];
                pv_wdata = id_link;
                n_queued[r_id[IW-1:0]] = 1'b1;
                n_total  = ins_total[AW-1:0];
                n_state  = lts_pkg::ST_FINISH;
            end
            lts_pkg::ST_WALK_DRAW: begin
                if (!cur_is_proc || (r_steps == SW'(NP))) begin
                    n_status = lts_pkg::STS_RANGE;
                    n_state  = lts_pkg::ST_FINISH;
                end else if (sum_add > r_rnd) begin
                    // hold the read address so the winner's links are on hand next
                    n_winner = r_cur[DW-1:0];
                    n_state  = lts_pkg::ST_UNLINK;
                end else begin
                    n_sum   = sum_add;
                    n_cur   = r_next_q;
                    rd_addr = r_next_q;
                    n_steps = r_steps + SW'(1);
                end
            end
            lts_pkg::ST_UNLINK: begin
                if (r_prev_q == HEAD) begin
                    n_head_next = r_next_q;
                end else begin
                    nx_we    = 1'b1;
                    nx_waddr = r_prev_q[IW-1:0];
                    nx_wdata = r_next_q;
                end
                if (r_next_q == TAIL) begin
                    n_tail_prev = r_prev_q;
                end else begin
                    pv_we    = 1'b1;
                    pv_waddr = r_next_q[IW-1:0];
                    pv_wdata = r_prev_q;
                end
                n_queued[r_cur[IW-1:0]] = 1'b0;
                n_total = r_total - AW'(r_tick_q);
                n_state = lts_pkg::ST_FINISH;
            end
            lts_pkg::ST_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_winner  = r_winner;
                    n_o_total   = r_total;
                    n_state     = lts_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lts_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_o_status;
    assign o_winner_id    = r_o_winner;
    assign o_ticket_total = r_o_total;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == lts_pkg::ST_START))
        else $error("accepted word did not start the sequencer");

    a_insert_not_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lts_pkg::ST_LINK_B) |-> !r_queued[r_id[IW-1:0]])
        else $error("linking a slot that is already queued");

    a_unlink_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lts_pkg::ST_UNLINK) |-> r_queued[r_cur[IW-1:0]])
        else $error("unlinking a slot that is not queued");

    a_empty_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head_next == TAIL) |-> ((r_queued == '0) && (r_total == '0)))
        else $error("empty list with queued flags or tickets left");

    a_finish_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == lts_pkg::ST_FINISH) && r_out_valid && !i_ready)
        |=> (r_state == lts_pkg::ST_FINISH))
        else $error("result dropped while output register was full");

endmodule
`default_nettype wire

[verif/tb_lottery_ticket_scheduler_top.sv]
// Self-checking testbench for the lottery ticket scheduler: ready list, draws and totals.
`timescale 1ns / 100ps
module tb_lottery_ticket_scheduler_top;

    localparam int MAX_PROCS = lts_pkg::MAX_PROCS;
    localparam int HEAD_SLOT = lts_pkg::HEAD_SLOT;
    localparam int TAIL_SLOT = lts_pkg::TAIL_SLOT;
    localparam int LINK_W    = lts_pkg::LINK_W;
    localparam int ID_W      = lts_pkg::ID_W;
    localparam int TICK_W    = lts_pkg::TICK_W;
    localparam int TOTAL_W   = lts_pkg::TOTAL_W;

    localparam int NUM_CMDS = 2000;
    localparam logic [TOTAL_W:0] TOTAL_MAX = {1'b0, {TOTAL_W{1'b1}}};

    // receiver stall patterns
    localparam int RX_OPEN   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_BURSTY = 2;
    localparam int RX_THIRD  = 3;

    typedef struct {
        lts_pkg::t_cmd        cmd;
        logic [ID_W-1:0]      id;
        logic [TICK_W-1:0]    tickets;
        logic [TOTAL_W-1:0]   rnd;
    } t_sched_word;

    typedef struct {
        lts_pkg::t_status     status;
        logic [ID_W-1:0]      winner;
        logic [TOTAL_W-1:0]   total;
    } t_sched_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [1:0]           i_cmd = '0;
    logic [ID_W-1:0]      i_proc_id = '0;
    logic [TICK_W-1:0]    i_tickets = '0;
    logic [TOTAL_W-1:0]   i_random_value = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [1:0]           o_status;
    logic [ID_W-1:0]      o_winner_id;
    logic [TOTAL_W-1:0]   o_ticket_total;

    lottery_ticket_scheduler_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_proc_id      (i_proc_id),
        .i_tickets      (i_tickets),
        .i_random_value (i_random_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_winner_id    (o_winner_id),
        .o_ticket_total (o_ticket_total)
    );

    always #1 i_clk = ~i_clk;

    // scheduler state as the testbench sees it
    logic [TICK_W-1:0]  slot_tickets [MAX_PROCS];
    logic [LINK_W-1:0]  slot_next [MAX_PROCS+2];
    logic [LINK_W-1:0]  slot_prev [MAX_PROCS+2];
    bit                 slot_queued [MAX_PROCS];
    logic [TOTAL_W-1:0] sched_total;

    t_sched_word   sched_cmd_q [$];
    t_sched_result sched_resp_q [$];
    int            cmds_sent = 0;
    int            cmds_taken = 0;
    int            mismatches = 0;

    function automatic void drop_slot(logic [ID_W-1:0] id);
        logic [LINK_W-1:0] p;
        logic [LINK_W-1:0] n;
        p = slot_prev[id];
        n = slot_next[id];
        slot_next[p] = n;
        slot_prev[n] = p;
        slot_queued[id] = 1'b0;
        sched_total = sched_total - TOTAL_W'(slot_tickets[id]);
    endfunction

    function automatic t_sched_result sched_apply(t_sched_word w);
        t_sched_result     r;
        logic [LINK_W-1:0] cur;
        logic [LINK_W-1:0] p;
        logic [TOTAL_W:0]  run_sum;
        int                steps;
        bit                found;
        r.status = lts_pkg::STS_OK;
        r.winner = '0;
        case (w.cmd)
            lts_pkg::CMD_INSERT: begin
                if (w.id >= MAX_PROCS) begin
                    r.status = lts_pkg::STS_BAD_ID;
                end else if (slot_queued[w.id]) begin
                    r.status = lts_pkg::STS_DUP_ABSENT;
                end else if ({1'b0, sched_total} + (TOTAL_W + 1)'(w.tickets) > TOTAL_MAX) begin
                    r.status = lts_pkg::STS_RANGE;
                end else begin
                    // descending tickets, ties by ascending id
                    cur = slot_next[HEAD_SLOT];
                    steps = 0;
                    while (cur != TAIL_SLOT && cur < MAX_PROCS && steps < MAX_PROCS &&
                           (slot_tickets[cur] > w.tickets ||
                            (slot_tickets[cur] == w.tickets && cur < w.id))) begin
                        cur = slot_next[cur];
                        steps++;
                    end
                    p = slot_prev[cur];
                    slot_tickets[w.id] = w.tickets;
                    slot_next[w.id] = cur;
                    slot_prev[w.id] = p;
                    slot_next[p] = LINK_W'(w.id);
                    slot_prev[cur] = LINK_W'(w.id);
                    slot_queued[w.id] = 1'b1;
                    sched_total = sched_total + TOTAL_W'(w.tickets);
                end
            end
            lts_pkg::CMD_DRAW: begin
                if (w.rnd >= sched_total) begin
                    r.status = lts_pkg::STS_RANGE;
                end else begin
                    cur = slot_next[HEAD_SLOT];
                    run_sum = '0;
                    steps = 0;
                    found = 1'b0;
                    while (!found && cur < MAX_PROCS && steps < MAX_PROCS) begin
                        run_sum = run_sum + (TOTAL_W + 1)'(slot_tickets[cur]);
                        if (run_sum > w.rnd) begin
                            found = 1'b1;
                        end else begin
                            cur = slot_next[cur];
                            steps++;
                        end
                    end
                    if (found) begin
                        r.winner = cur[ID_W-1:0];
                        drop_slot(cur[ID_W-1:0]);
                    end else begin
                        r.status = lts_pkg::STS_RANGE;
                    end
                end
            end
            lts_pkg::CMD_REMOVE: begin
                if (w.id >= MAX_PROCS) begin
                    r.status = lts_pkg::STS_BAD_ID;
                end else if (!slot_queued[w.id]) begin
                    r.status = lts_pkg::STS_DUP_ABSENT;
                end else begin
                    drop_slot(w.id);
                end
            end
            default: ;
        endcase
        r.total = sched_total;
        return r;
    endfunction

    // check results, then take in the word accepted at this edge
    t_sched_word   taken_word;
    t_sched_result want;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (sched_resp_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: status %0d winner %0d total %0d",
                             $time, o_status, o_winner_id, o_ticket_total);
                end else begin
                    want = sched_resp_q.pop_front();
                    if (o_status !== want.status) begin
                        mismatches++;
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, o_status);
                    end
                    if (o_winner_id !== want.winner) begin
                        mismatches++;
                        $display("%0t: winner_id expected %0d got %0d",
                                 $time, want.winner, o_winner_id);
                    end
                    if (o_ticket_total !== want.total) begin
                        mismatches++;
                        $display("%0t: ticket_total expected %0d got %0d",
                                 $time, want.total, o_ticket_total);
                    end
                end
            end
            if (i_valid && o_ready) begin
                taken_word.cmd = lts_pkg::t_cmd'(i_cmd);
                taken_word.id = i_proc_id;
                taken_word.tickets = i_tickets;
                taken_word.rnd = i_random_value;
                sched_resp_q.push_back(sched_apply(taken_word));
                cmds_taken++;
            end
        end
    end

    // sender: bursts of words with random gaps between them
    int          burst_left = 0;
    int          gap_left = 0;
    bit          go;
    t_sched_word next_word;
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || cmds_taken == cmds_sent)) begin
            go = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (sched_cmd_q.size() > 0) begin
                next_word = sched_cmd_q.pop_front();
                go = 1'b1;
                cmds_sent++;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
            i_valid <= go;
            if (go) begin
                i_cmd <= next_word.cmd;
                i_proc_id <= next_word.id;
                i_tickets <= next_word.tickets;
                i_random_value <= next_word.rnd;
            end
        end
    end

    // receiver: open, coin-flip, bursty or every-third stall pattern, drawn at random
    int rx_cycle = 0;
    int rx_mode = RX_OPEN;
    int stall_left = 0;
    bit rdy;
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 256 == 0) begin
            rx_mode = $urandom_range(RX_OPEN, RX_THIRD);
        end
        if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN: rdy = 1'b1;
                RX_COIN: rdy = 1'($urandom_range(0, 1));
                RX_BURSTY: begin
                    if ($urandom_range(0, 15) == 0) begin
                        stall_left = $urandom_range(1, 40);
                    end
                    rdy = (stall_left == 0);
                end
                default: rdy = (rx_cycle % 3 == 0);
            endcase
        end
        i_ready <= rdy;
    end

    task automatic push_word(lts_pkg::t_cmd cmd, logic [ID_W-1:0] id,
                             logic [TICK_W-1:0] tickets, logic [TOTAL_W-1:0] rnd);
        t_sched_word w;
        while (sched_cmd_q.size() >= 2) begin
            @(posedge i_clk);
            #0.2;
        end
        w.cmd = cmd;
        w.id = id;
        w.tickets = tickets;
        w.rnd = rnd;
        sched_cmd_q.push_back(w);
    endtask

    // hold off until every word is taken and answered
    task automatic drain();
        while (sched_cmd_q.size() > 0 || cmds_taken != cmds_sent ||
               sched_resp_q.size() > 0) begin
            @(posedge i_clk);
            #0.2;
        end
    endtask

    function automatic logic [ID_W-1:0] pick_slot(bit want_queued);
        int base;
        logic [ID_W-1:0] id;
        base = $urandom_range(0, MAX_PROCS - 1);
        for (int k = 0; k < MAX_PROCS; k++) begin
            id = ID_W'((base + k) % MAX_PROCS);
            if (slot_queued[id] == want_queued) return id;
        end
        return ID_W'(base);
    endfunction

    initial begin
        int                 n_cmds;
        int                 phase_len;
        int                 mix;
        int                 tick_mode;
        int                 roll;
        int                 ins_pct;
        int                 draw_pct;
        int                 rm_pct;
        logic [TICK_W-1:0]  tk;
        logic [TOTAL_W-1:0] rv;

        for (int k = 0; k < MAX_PROCS; k++) begin
            slot_tickets[k] = '0;
            slot_queued[k] = 1'b0;
        end
        for (int k = 0; k < MAX_PROCS + 2; k++) begin
            slot_next[k] = '0;
            slot_prev[k] = '0;
        end
        slot_next[HEAD_SLOT] = LINK_W'(TAIL_SLOT);
        slot_prev[TAIL_SLOT] = LINK_W'(HEAD_SLOT);
        sched_total = '0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, absent slot, ignored command, ties, extremes
        push_word(lts_pkg::CMD_DRAW, '1, '1, '0);
        push_word(lts_pkg::CMD_REMOVE, ID_W'(5), '0, '0);
        push_word(lts_pkg::CMD_NOP, '1, '1, '1);
        push_word(lts_pkg::CMD_INSERT, ID_W'(7), '0, '1);
        push_word(lts_pkg::CMD_DRAW, '0, '0, '0);
        push_word(lts_pkg::CMD_INSERT, ID_W'(3), TICK_W'(100), '0);
        push_word(lts_pkg::CMD_INSERT, ID_W'(9), TICK_W'(100), '0);
        push_word(lts_pkg::CMD_INSERT, ID_W'(1), TICK_W'(100), '0);
        push_word(lts_pkg::CMD_INSERT, '1, '1, '0);
        push_word(lts_pkg::CMD_INSERT, '0, TICK_W'(1), '0);
        push_word(lts_pkg::CMD_INSERT, ID_W'(3), TICK_W'(5), '0);
        push_word(lts_pkg::CMD_DRAW, '0, '0, '0);
        drain();
        push_word(lts_pkg::CMD_DRAW, '0, '0, sched_total - 1'b1);
        drain();
        push_word(lts_pkg::CMD_DRAW, '0, '0, sched_total);
        push_word(lts_pkg::CMD_DRAW, '0, '0, '1);
        push_word(lts_pkg::CMD_REMOVE, ID_W'(7), '1, '1);
        push_word(lts_pkg::CMD_REMOVE, '1, '0, '0);
        push_word(lts_pkg::CMD_REMOVE, ID_W'(1), '0, '0);
        push_word(lts_pkg::CMD_INSERT, ID_W'(1), '1, '0);
        drain();

        // random phases: fill-heavy, draw-heavy and balanced mixes
        n_cmds = 0;
        while (n_cmds < NUM_CMDS) begin
            phase_len = $urandom_range(20, 150);
            mix = $urandom_range(0, 2);
            tick_mode = $urandom_range(0, 3);
            case (mix)
                0: begin ins_pct = 70; draw_pct = 85; rm_pct = 95; end
                1: begin ins_pct = 20; draw_pct = 65; rm_pct = 95; end
                default: begin ins_pct = 40; draw_pct = 70; rm_pct = 95; end
            endcase
            for (int k = 0; k < phase_len; k++) begin
                case (tick_mode)
                    0: tk = TICK_W'($urandom);
                    1: tk = TICK_W'($urandom_range(0, 7));
                    2: tk = TICK_W'($urandom_range(16'hF000, 16'hFFFF));
                    default: begin
                        roll = $urandom_range(0, 2);
                        tk = (roll == 0) ? '0 : (roll == 1) ? '1 : TICK_W'($urandom);
                    end
                endcase
                roll = $urandom_range(0, 9);
                if (roll < 8 && sched_total != 0) begin
                    rv = TOTAL_W'($urandom_range(0, int'(sched_total) - 1));
                end else if (roll == 8) begin
                    rv = sched_total;
                end else begin
                    rv = TOTAL_W'($urandom);
                end
                roll = $urandom_range(0, 99);
                if (roll < ins_pct) begin
                    push_word(lts_pkg::CMD_INSERT,
                              ($urandom_range(0, 4) != 0) ? pick_slot(1'b0) : ID_W'($urandom),
                              tk, TOTAL_W'($urandom));
                end else if (roll < draw_pct) begin
                    push_word(lts_pkg::CMD_DRAW, ID_W'($urandom), TICK_W'($urandom), rv);
                end else if (roll < rm_pct) begin
                    push_word(lts_pkg::CMD_REMOVE,
                              ($urandom_range(0, 9) < 7) ? pick_slot(1'b1) : ID_W'($urandom),
                              TICK_W'($urandom), TOTAL_W'($urandom));
                end else begin
                    push_word(lts_pkg::CMD_NOP, ID_W'($urandom), TICK_W'($urandom),
                              TOTAL_W'($urandom));
                    n_cmds--;
                end
                n_cmds++;
            end
            if ($urandom_range(0, 3) == 0) begin
                drain();
            end
        end

        drain();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && sched_resp_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
sv/lts_pkg.sv
sv/lottery_ticket_scheduler_top.sv
verif/tb_lottery_ticket_scheduler_top.sv
